>>> sv/i2c_master_transaction_engine_assert.svh
// Assertion macros shared by the I2C master transaction engine modules.
`ifndef I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH
`define I2C_MASTER_TRANSACTION_ENGINE_ASSERT_SVH

// Checked on every clock edge outside reset.
`define I2CM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define I2CM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

>>> sv/i2cm_pkg.sv
// Types, codes and constants of the I2C master transaction engine.
package i2cm_pkg;

    // Register map and reset values
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_WAIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CMD_GAP  = 1'd1;
    localparam logic [15:0] ACK_WAIT_RESET = 16'd22400;
    localparam logic [7:0]  CMD_GAP_RESET  = 8'd50;
    localparam int          QUEUE_DEPTH_DEFAULT = 2;

    // Widths of the stream payloads
    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 16;

    // Input action codes
    localparam logic [1:0] ACT_BEGIN  = 2'd0;
    localparam logic [1:0] ACT_SUPPLY = 2'd1;
    localparam logic [1:0] ACT_TICK   = 2'd2;

    // Transaction kinds
    localparam logic [1:0] KIND_REG_WRITE = 2'd0;
    localparam logic [1:0] KIND_REG_READ  = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;
    localparam logic [1:0] KIND_CMD_WRITE = 2'd3;

    typedef enum logic [1:0] {
        OP_BEGIN,
        OP_SUPPLY,
        OP_TICK
    } t_op;

    // One classified transaction handed from front to back
    typedef struct packed {
        t_op        op;
        logic [1:0] kind;
        logic [7:0] slave_address;
        logic [7:0] register_address;
        logic [7:0] byte_count;
        logic [7:0] write_byte;
        logic       sda_sample;
    } t_item;

    // Configuration write
    typedef struct packed {
        logic                 valid;
        logic [CFG_IDX_W-1:0] index;
        logic [15:0]          data;
    } t_cfg_wr;

    // One result item
    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_driving;
        logic [7:0] read_byte;
        logic       read_valid;
        logic       need_data;
        logic       done_res;
        logic       status;
        logic       busy_res;
    } t_result;

    typedef struct packed {
        logic scl;
        logic sda;
        logic drv;
    } t_lines;

    typedef enum logic [11:0] {
        PH_IDLE      = 12'b0000_0000_0001,
        PH_START     = 12'b0000_0000_0010,
        PH_TX        = 12'b0000_0000_0100,
        PH_APREP     = 12'b0000_0000_1000,
        PH_AWAIT     = 12'b0000_0001_0000,
        PH_AEND      = 12'b0000_0010_0000,
        PH_GAP       = 12'b0000_0100_0000,
        PH_NEED      = 12'b0000_1000_0000,
        PH_RX        = 12'b0001_0000_0000,
        PH_RACK      = 12'b0010_0000_0000,
        PH_STOP_OK   = 12'b0100_0000_0000,
        PH_STOP_FAIL = 12'b1000_0000_0000
    } t_phase;

    // What follows the acknowledge in progress
    typedef enum logic [2:0] {
        AA_NONE,
        AA_REG,
        AA_DATA,
        AA_RSTART,
        AA_READ,
        AA_GAP,
        AA_STOP,
        AA_FAIL
    } t_after;

endpackage

>>> sv/i2cm_front.sv
// Front end: takes stream transactions, unpacks and classifies them.
module i2cm_front
    import i2cm_pkg::*;
(
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [IN_DATA_W-1:0] s_axis_tdata,
    input  logic [IN_USER_W-1:0] s_axis_tuser,
    input  logic                 i_queue_full,
    output logic                 o_push,
    output t_item                o_item
);

    logic       w_accept;
    logic       w_is_read;
    logic [1:0] w_kind;
    logic [7:0] w_count;

    assign s_axis_tready = !i_queue_full;
    assign w_accept      = s_axis_tvalid && !i_queue_full;

    // Unpack; reads of length zero are turned into reads of one byte here
    assign w_kind    = s_axis_tdata[1:0];
    assign w_count   = s_axis_tdata[25:18];
    assign w_is_read = (w_kind == KIND_REG_READ) || (w_kind == KIND_READ);

    always_comb begin
        o_item.kind             = w_kind;
        o_item.slave_address    = s_axis_tdata[9:2];
        o_item.register_address = s_axis_tdata[17:10];
        o_item.byte_count       = (w_is_read && w_count == 8'd0) ? 8'd1 : w_count;
        o_item.write_byte       = s_axis_tdata[33:26];
        o_item.sda_sample       = s_axis_tdata[34];
        o_item.op               = OP_TICK;
        o_push                  = 1'b0;
        case (s_axis_tuser)
            ACT_BEGIN: begin
                o_item.op = OP_BEGIN;
                o_push    = w_accept;
            end
            ACT_SUPPLY: begin
                o_item.op = OP_SUPPLY;
                o_push    = w_accept;
            end
            ACT_TICK: begin
                o_item.op = OP_TICK;
                o_push    = w_accept;
            end
            default: begin
                // no-op action: taken and dropped
                o_push = 1'b0;
            end
        endcase
    end

endmodule

>>> sv/i2cm_queue.sv
// Short register queue between front and back.
module i2cm_queue
    import i2cm_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    `include "i2c_master_transaction_engine_assert.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    `I2CM_ASSERT(a_pop_not_empty, i_pop |-> (r_count != '0), "queue popped while empty")
    `I2CM_ASSERT(a_count_bound, r_count <= FULL_CNT, "queue fill count beyond depth")
    `I2CM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> (r_count == '0), "queue not empty after reset")

endmodule

>>> sv/i2cm_back.sv
// Back end: bus sequencer, configuration registers and result register.
module i2cm_back
    import i2cm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cfg_wr               i_cfg,
    input  logic                  i_item_valid,
    input  t_item                 i_item,
    output logic                  o_pop,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast
);

    `include "i2c_master_transaction_engine_assert.svh"

    // Configuration
    logic [15:0] r_ack_wait_limit;
    logic [7:0]  r_cmd_gap;

    // Sequencer state
    t_phase      r_phase, n_phase;
    t_after      r_after, n_after;
    logic [3:0]  r_bit_cnt, n_bit_cnt;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [15:0] r_ack_timer, n_ack_timer;
    logic [7:0]  r_gap_timer, n_gap_timer;
    logic [1:0]  r_held_kind, n_held_kind;
    logic [7:0]  r_held_addr, n_held_addr;
    logic [7:0]  r_held_reg, n_held_reg;
    logic [7:0]  r_pend_byte, n_pend_byte;
    logic        r_pend_valid, n_pend_valid;
    t_lines      r_lines, n_lines;

    // Result register
    t_result     r_res, w_res;
    logic        r_res_valid;

    logic        w_slot_free;
    logic        w_fire;
    logic [15:0] w_ack_next;

    assign w_slot_free = !r_res_valid || m_axis_tready;
    assign w_fire      = i_item_valid && (i_item.op != OP_TICK || w_slot_free);
    assign o_pop       = w_fire;
    assign w_ack_next  = r_ack_timer + 16'd1;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_wait_limit <= ACK_WAIT_RESET;
            r_cmd_gap        <= CMD_GAP_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ACK_WAIT: r_ack_wait_limit <= i_cfg.data;
                CFG_CMD_GAP:  r_cmd_gap        <= i_cfg.data[7:0];
                default:      ;
            endcase
        end
    end

    // Next state for one transaction popped from the queue
    always_comb begin
        n_phase      = r_phase;
        n_after      = r_after;
        n_bit_cnt    = r_bit_cnt;
        n_shift      = r_shift;
        n_bytes_left = r_bytes_left;
        n_ack_timer  = r_ack_timer;
        n_gap_timer  = r_gap_timer;
        n_held_kind  = r_held_kind;
        n_held_addr  = r_held_addr;
        n_held_reg   = r_held_reg;
        n_pend_byte  = r_pend_byte;
        n_pend_valid = r_pend_valid;
        n_lines      = r_lines;
        w_res        = '0;

        case (i_item.op)
            OP_BEGIN: begin
                // ignored unless idle
                if (r_phase == PH_IDLE) begin
                    n_held_kind  = i_item.kind;
                    n_held_addr  = i_item.slave_address;
                    n_held_reg   = i_item.register_address;
                    n_bytes_left = i_item.byte_count;
                    n_pend_valid = 1'b0;
                    n_ack_timer  = '0;
                    n_shift      = i_item.slave_address;
                    n_phase      = PH_START;
                    n_bit_cnt    = '0;
                    case (i_item.kind)
                        KIND_READ:      n_after = AA_READ;
                        KIND_CMD_WRITE: n_after = AA_GAP;
                        default:        n_after = AA_REG;
                    endcase
                end
            end
            OP_SUPPLY: begin
                n_pend_byte  = i_item.write_byte;
                n_pend_valid = 1'b1;
            end
            default: begin
                // one bus delay period
                case (r_phase)
                    PH_IDLE: begin
                        n_lines = r_lines;
                    end
                    PH_START: begin
                        n_lines = '{scl: (r_bit_cnt != 4'd0), sda: (r_bit_cnt != 4'd3),
                                    drv: 1'b1};
                        if (r_bit_cnt >= 4'd3) begin
                            n_phase   = PH_TX;
                            n_bit_cnt = '0;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    PH_TX: begin
                        n_lines = '{scl: r_bit_cnt[0], sda: r_shift[7], drv: 1'b1};
                        if (r_bit_cnt[0]) begin
                            n_shift = {r_shift[6:0], 1'b0};
                        end
                        if (r_bit_cnt == 4'd15) begin
                            n_phase   = PH_APREP;
                            n_bit_cnt = '0;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    PH_APREP: begin
                        n_lines = '{scl: 1'b0, sda: 1'b1, drv: (r_bit_cnt < 4'd2)};
                        if (r_bit_cnt >= 4'd2) begin
                            n_phase     = PH_AWAIT;
                            n_bit_cnt   = '0;
                            n_ack_timer = '0;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    PH_AWAIT: begin
                        n_lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b0};
                        if (!i_item.sda_sample) begin
                            n_phase = PH_AEND;
                        end else begin
                            n_ack_timer = w_ack_next;
                            if (w_ack_next >= r_ack_wait_limit || w_ack_next == 16'd0) begin
                                n_after = AA_FAIL;
                                n_phase = PH_AEND;
                            end
                        end
                    end
                    PH_AEND: begin
                        n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
                        n_bit_cnt = '0;
                        case (r_after)
                            AA_REG: begin
                                n_shift = r_held_reg;
                                n_after = (r_held_kind == KIND_REG_READ) ? AA_RSTART : AA_DATA;
                                n_phase = PH_TX;
                            end
                            AA_DATA: begin
                                if (r_bytes_left == 8'd0) begin
                                    n_phase = PH_STOP_OK;
                                end else begin
                                    n_phase   = PH_NEED;
                                    n_bit_cnt = r_bit_cnt;
                                end
                            end
                            AA_RSTART: begin
                                n_shift = r_held_addr + 8'd1;
                                n_after = AA_READ;
                                n_phase = PH_START;
                            end
                            AA_READ: begin
                                n_phase = PH_RX;
                                n_shift = '0;
                            end
                            AA_GAP: begin
                                n_gap_timer = r_cmd_gap;
                                if (r_cmd_gap == 8'd0) begin
                                    n_shift = r_held_reg;
                                    n_after = AA_STOP;
                                    n_phase = PH_TX;
                                end else begin
                                    n_phase   = PH_GAP;
                                    n_bit_cnt = r_bit_cnt;
                                end
                            end
                            AA_FAIL: begin
                                n_phase = PH_STOP_FAIL;
                            end
                            default: begin
                                n_phase = PH_STOP_OK;
                            end
                        endcase
                    end
                    PH_GAP: begin
                        n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
                        n_gap_timer = r_gap_timer - 8'd1;
                        if (r_gap_timer == 8'd1) begin
                            n_shift   = r_held_reg;
                            n_after   = AA_STOP;
                            n_phase   = PH_TX;
                            n_bit_cnt = '0;
                        end
                    end
                    PH_NEED: begin
                        n_lines = '{scl: 1'b0, sda: 1'b1, drv: 1'b0};
                        w_res.need_data = !r_pend_valid;
                        if (r_pend_valid) begin
                            n_pend_valid = 1'b0;
                            n_bytes_left = r_bytes_left - 8'd1;
                            n_shift      = r_pend_byte;
                            n_after      = AA_DATA;
                            n_phase      = PH_TX;
                            n_bit_cnt    = '0;
                        end
                    end
                    PH_RX: begin
                        n_lines = '{scl: r_bit_cnt[0], sda: 1'b1, drv: 1'b0};
                        if (r_bit_cnt[0]) begin
                            n_shift = {r_shift[6:0], i_item.sda_sample};
                        end
                        if (r_bit_cnt == 4'd15) begin
                            w_res.read_valid = 1'b1;
                            w_res.read_byte  = n_shift;
                            n_phase          = PH_RACK;
                            n_bit_cnt        = '0;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    PH_RACK: begin
                        // acknowledge all but the last byte
                        n_lines = '{scl: (r_bit_cnt == 4'd1), sda: (r_bytes_left <= 8'd1),
                                    drv: 1'b1};
                        if (r_bit_cnt >= 4'd2) begin
                            n_bit_cnt = '0;
                            if (r_bytes_left <= 8'd1) begin
                                n_bytes_left = '0;
                                n_phase      = PH_STOP_OK;
                            end else begin
                                n_bytes_left = r_bytes_left - 8'd1;
                                n_phase      = PH_RX;
                                n_shift      = '0;
                            end
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    PH_STOP_OK, PH_STOP_FAIL: begin
                        n_lines = '{scl: (r_bit_cnt != 4'd0), sda: (r_bit_cnt >= 4'd3),
                                    drv: 1'b1};
                        if (r_bit_cnt >= 4'd3) begin
                            w_res.done_res = 1'b1;
                            w_res.status   = (r_phase == PH_STOP_FAIL);
                            n_phase        = PH_IDLE;
                            n_bit_cnt      = '0;
                            n_after        = AA_NONE;
                        end else begin
                            n_bit_cnt = r_bit_cnt + 4'd1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
                w_res.scl_level   = n_lines.scl;
                w_res.sda_level   = n_lines.sda;
                w_res.sda_driving = n_lines.drv;
                w_res.busy_res    = (n_phase != PH_IDLE);
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_after      <= AA_NONE;
            r_bit_cnt    <= '0;
            r_shift      <= '0;
            r_bytes_left <= '0;
            r_ack_timer  <= '0;
            r_gap_timer  <= '0;
            r_held_kind  <= '0;
            r_held_addr  <= '0;
            r_held_reg   <= '0;
            r_pend_valid <= 1'b0;
            r_lines      <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
        end else if (w_fire) begin
            r_phase      <= n_phase;
            r_after      <= n_after;
            r_bit_cnt    <= n_bit_cnt;
            r_shift      <= n_shift;
            r_bytes_left <= n_bytes_left;
            r_ack_timer  <= n_ack_timer;
            r_gap_timer  <= n_gap_timer;
            r_held_kind  <= n_held_kind;
            r_held_addr  <= n_held_addr;
            r_held_reg   <= n_held_reg;
            r_pend_valid <= n_pend_valid;
            r_lines      <= n_lines;
        end
    end

    // Pending write byte: no reset, only read while its valid flag is set
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_pend_byte <= n_pend_byte;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (w_fire && i_item.op == OP_TICK) begin
            r_res_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_res_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && i_item.op == OP_TICK) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_res_valid;
    assign m_axis_tlast  = r_res.done_res;
    assign m_axis_tdata  = {1'b0, r_res.busy_res, r_res.status, r_res.need_data,
                            r_res.read_valid, r_res.read_byte, r_res.sda_driving,
                            r_res.sda_level, r_res.scl_level};

    `I2CM_ASSERT(a_done_not_busy, (r_res_valid && r_res.done_res) |-> !r_res.busy_res, "done result still busy")
    `I2CM_ASSERT(a_status_with_done, (r_res_valid && r_res.status) |-> r_res.done_res, "status without done")
    `I2CM_ASSERT(a_need_in_need_phase, (r_res_valid && r_res.need_data) |-> (r_phase == PH_NEED), "need_data outside byte wait")

endmodule

>>> sv/i2c_master_transaction_engine.sv
// Top level of the I2C master transaction engine.
//
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata: kind, slave_address, register_address,
//                                               byte_count, write_byte, sda_sample; tuser: action
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata: pin levels and status; tlast: done_res
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// One transaction a cycle on each side: the back end retires one queued item per cycle,
// a tick item needing the result register to be free or emptied in that cycle.
// Begin, supply and no-op items give no result and never wait on the output side.
// The queue between front and back holds QUEUE_DEPTH items; s_axis_tready drops when full.
// Reset is synchronous and active low; afterwards both lines read high, with SDA driven.
// Configuration is always ready; the user must write it only while the engine is idle, the block does not enforce it.
module i2c_master_transaction_engine
    import i2cm_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // [1:0] kind, [9:2] slave_address, [17:10] register_address, [25:18] byte_count,
    // [33:26] write_byte, [34] sda_sample, [39:35] zero
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] action
    input  logic [IN_USER_W-1:0]  s_axis_tuser,
    // [0] scl_level, [1] sda_level, [2] sda_driving, [10:3] read_byte, [11] read_valid,
    // [12] need_data, [13] status, [14] busy_res, [15] zero
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [15:0]           i_cfg_data
);

    logic    w_push;
    logic    w_full;
    logic    w_pop;
    logic    w_q_valid;
    t_item   w_front_item;
    t_item   w_q_item;
    t_cfg_wr w_cfg;

    assign o_cfg_ready = 1'b1;
    assign w_cfg       = '{valid: i_cfg_valid, index: i_cfg_index, data: i_cfg_data};

    i2cm_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    i2cm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_item_valid  (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

>>> test/i2c_master_transaction_engine_tb.sv
// Self-checking testbench of the I2C master transaction engine: directed transfers, then random ones.
module i2c_master_transaction_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cm_pkg::*;

    // How the simulated slave answers acknowledge windows
    typedef enum logic [1:0] {
        ACK_NOW,
        ACK_LATE,
        ACK_NEVER,
        ACK_FIRST_ONLY
    } t_ack;

    // Where the expected pin levels come from
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_IDLE_LINES,
        CHK_DONE_OK,
        CHK_DONE_FAIL
    } t_chk;

    // One input item as the sender sees it
    typedef struct packed {
        logic [1:0] act;
        logic [1:0] kind;
        logic [7:0] addr;
        logic [7:0] reg_b;
        logic [7:0] cnt;
        logic [7:0] wb;
        logic       sda;
    } t_stim;

    // One I2C transfer: timing it runs under, what it does, how the slave behaves
    typedef struct packed {
        logic [15:0] ack_lim;
        logic [7:0]  gap;
        logic [1:0]  kind;
        logic [7:0]  addr;
        logic [7:0]  reg_b;
        logic [7:0]  cnt;
        t_ack        ack;
        t_chk        chk;
        logic [3:0]  pre_idle;
    } t_row;

    localparam int NROWS = 17;
    localparam t_row PLAN [NROWS] = '{
        // reset timing; write of one byte straight after reset
        '{16'd22400, 8'd50,  KIND_REG_WRITE, 8'h00, 8'h00, 8'd1,   ACK_NOW,   CHK_DONE_OK,   4'd3},
        // write length zero: address and register only
        '{16'd22400, 8'd50,  KIND_REG_WRITE, 8'hFF, 8'hFF, 8'd0,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd22400, 8'd50,  KIND_CMD_WRITE, 8'hA5, 8'h5A, 8'd0,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        // no command gap
        '{16'd1,     8'd0,   KIND_CMD_WRITE, 8'h3C, 8'hC3, 8'd7,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd1,     8'd255, KIND_CMD_WRITE, 8'h81, 8'h7E, 8'd0,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        // read length zero, and the read address wrapping past 0xFF
        '{16'd1,     8'd255, KIND_REG_READ,  8'hFF, 8'h10, 8'd0,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd1,     8'd255, KIND_READ,      8'h55, 8'h00, 8'd0,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd1,     8'd255, KIND_READ,      8'hAA, 8'h00, 8'd3,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        // limit of one: first high sample gives up
        '{16'd1,     8'd255, KIND_REG_WRITE, 8'h42, 8'h01, 8'd3,   ACK_NEVER, CHK_DONE_FAIL, 4'd1},
        // limit of zero behaves the same
        '{16'd0,     8'd0,   KIND_READ,      8'h12, 8'h00, 8'd2,   ACK_NEVER, CHK_DONE_FAIL, 4'd1},
        '{16'd0,     8'd0,   KIND_REG_READ,  8'h34, 8'h56, 8'd2,   ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd65535, 8'd0,   KIND_REG_WRITE, 8'h78, 8'h9A, 8'd4,   ACK_LATE,  CHK_DONE_OK,   4'd1},
        // full-length wait before giving up
        '{16'd65535, 8'd0,   KIND_READ,      8'h01, 8'h00, 8'd1,   ACK_NEVER, CHK_DONE_FAIL, 4'd1},
        '{16'd65535, 8'd0,   KIND_REG_READ,  8'h80, 8'h7F, 8'd255, ACK_NOW,   CHK_DONE_OK,   4'd1},
        '{16'd65535, 8'd0,   KIND_REG_WRITE, 8'h7F, 8'h80, 8'd255, ACK_NOW,   CHK_DONE_OK,   4'd1},
        // address acknowledged, later byte refused
        '{16'd3,     8'd2,   KIND_REG_WRITE, 8'h11, 8'h22, 8'd2,   ACK_FIRST_ONLY, CHK_DONE_FAIL, 4'd1},
        '{16'd3,     8'd2,   KIND_CMD_WRITE, 8'h22, 8'h33, 8'd0,   ACK_FIRST_ONLY, CHK_DONE_FAIL, 4'd1}
    };

    localparam int SEND_IDLE [4]  = '{0, 73, 0, 33};
    localparam int RECV_STALL [4] = '{0, 0, 73, 33};
    localparam int ITEMS_PER_PHASE = 215;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_USER_W-1:0]  s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [15:0]           i_cfg_data = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatches = 0;
    int items_sent = 0;

    // Pin levels still owed by the engine, oldest first
    t_result expected_pins [$];

    // Shadow of the engine state
    t_phase      bus_phase = PH_IDLE;
    t_after      next_step = AA_NONE;
    logic [3:0]  bit_cnt = '0;
    logic [7:0]  shreg = '0;
    logic [7:0]  left_cnt = '0;
    logic [15:0] ack_cnt = '0;
    logic [7:0]  gap_cnt = '0;
    logic [1:0]  txn_kind = KIND_REG_WRITE;
    logic [7:0]  txn_addr = '0;
    logic [7:0]  txn_reg = '0;
    logic [7:0]  pend_byte = '0;
    logic        pend_ok = 1'b0;
    t_lines      lines = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
    logic [15:0] ack_limit = ACK_WAIT_RESET;
    logic [7:0]  gap_len = CMD_GAP_RESET;

    i2c_master_transaction_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Load a byte to shift out, starting either with a start condition or straight away
    function automatic void load_byte(input logic [7:0] b, input t_after nxt, input t_phase ph);
        shreg = b;
        next_step = nxt;
        bus_phase = ph;
        bit_cnt = '0;
    endfunction

    // Decide what follows a finished acknowledge window
    function automatic void after_acknowledge();
        case (next_step)
            AA_REG: begin
                load_byte(txn_reg, (txn_kind == KIND_REG_READ) ? AA_RSTART : AA_DATA, PH_TX);
            end
            AA_DATA: begin
                if (left_cnt == 8'd0) begin
                    bus_phase = PH_STOP_OK;
                    bit_cnt = '0;
                end else begin
                    bus_phase = PH_NEED;
                end
            end
            AA_RSTART: load_byte(txn_addr + 8'd1, AA_READ, PH_START);
            AA_READ: begin
                bus_phase = PH_RX;
                bit_cnt = '0;
                shreg = '0;
            end
            AA_GAP: begin
                gap_cnt = gap_len;
                if (gap_cnt == 8'd0) load_byte(txn_reg, AA_STOP, PH_TX);
                else bus_phase = PH_GAP;
            end
            AA_FAIL: begin
                bus_phase = PH_STOP_FAIL;
                bit_cnt = '0;
            end
            default: begin
                bus_phase = PH_STOP_OK;
                bit_cnt = '0;
            end
        endcase
    endfunction

    // Advance the bus sequencer by one delay period and give the pins it drives
    function automatic t_result tick_engine(input logic sda_in);
        t_result r;
        logic [3:0] sub;
        r = '0;
        r.scl_level = lines.scl;
        r.sda_level = lines.sda;
        r.sda_driving = lines.drv;
        sub = bit_cnt;
        case (bus_phase)
            PH_START: begin
                r.scl_level = (sub != 4'd0);
                r.sda_level = (sub != 4'd3);
                r.sda_driving = 1'b1;
                if (sub >= 4'd3) begin
                    bus_phase = PH_TX;
                    bit_cnt = '0;
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            PH_TX: begin
                r.scl_level = sub[0];
                r.sda_level = shreg[7];
                r.sda_driving = 1'b1;
                if (sub[0]) shreg = shreg << 1;
                if (sub == 4'd15) begin
                    bus_phase = PH_APREP;
                    bit_cnt = '0;
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            PH_APREP: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b1;
                r.sda_driving = (sub < 4'd2);
                if (sub >= 4'd2) begin
                    bus_phase = PH_AWAIT;
                    bit_cnt = '0;
                    ack_cnt = '0;
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            PH_AWAIT: begin
                r.scl_level = 1'b1;
                r.sda_level = 1'b1;
                r.sda_driving = 1'b0;
                if (!sda_in) begin
                    bus_phase = PH_AEND;
                end else begin
                    ack_cnt = ack_cnt + 16'd1;
                    if (ack_cnt >= ack_limit || ack_cnt == 16'd0) begin
                        next_step = AA_FAIL;
                        bus_phase = PH_AEND;
                    end
                end
            end
            PH_AEND: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b1;
                r.sda_driving = 1'b0;
                after_acknowledge();
            end
            PH_GAP: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b1;
                r.sda_driving = 1'b0;
                gap_cnt = gap_cnt - 8'd1;
                if (gap_cnt == 8'd0) load_byte(txn_reg, AA_STOP, PH_TX);
            end
            PH_NEED: begin
                r.scl_level = 1'b0;
                r.sda_level = 1'b1;
                r.sda_driving = 1'b0;
                r.need_data = !pend_ok;
                if (pend_ok) begin
                    pend_ok = 1'b0;
                    left_cnt = left_cnt - 8'd1;
                    load_byte(pend_byte, AA_DATA, PH_TX);
                end
            end
            PH_RX: begin
                r.scl_level = sub[0];
                r.sda_level = 1'b1;
                r.sda_driving = 1'b0;
                if (sub[0]) shreg = {shreg[6:0], sda_in};
                if (sub == 4'd15) begin
                    r.read_valid = 1'b1;
                    r.read_byte = shreg;
                    bus_phase = PH_RACK;
                    bit_cnt = '0;
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            PH_RACK: begin
                // last byte gets a not-acknowledge
                r.scl_level = (sub == 4'd1);
                r.sda_level = (left_cnt <= 8'd1);
                r.sda_driving = 1'b1;
                if (sub >= 4'd2) begin
                    if (left_cnt != 8'd0) left_cnt = left_cnt - 8'd1;
                    if (left_cnt == 8'd0) begin
                        bus_phase = PH_STOP_OK;
                        bit_cnt = '0;
                    end else begin
                        bus_phase = PH_RX;
                        bit_cnt = '0;
                        shreg = '0;
                    end
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            PH_STOP_OK, PH_STOP_FAIL: begin
                r.scl_level = (sub != 4'd0);
                r.sda_level = (sub >= 4'd3);
                r.sda_driving = 1'b1;
                if (sub >= 4'd3) begin
                    r.done_res = 1'b1;
                    r.status = (bus_phase == PH_STOP_FAIL);
                    bus_phase = PH_IDLE;
                    bit_cnt = '0;
                    next_step = AA_NONE;
                end else begin
                    bit_cnt = sub + 4'd1;
                end
            end
            default: bus_phase = PH_IDLE;
        endcase
        lines = '{scl: r.scl_level, sda: r.sda_level, drv: r.sda_driving};
        r.busy_res = (bus_phase != PH_IDLE);
        return r;
    endfunction

    function automatic t_stim random_stim(input logic [1:0] act);
        t_stim s;
        s.act = act;
        s.kind = $urandom_range(3);
        s.addr = $urandom_range(255);
        s.reg_b = $urandom_range(255);
        s.cnt = $urandom_range(255);
        s.wb = $urandom_range(255);
        s.sda = $urandom_range(1);
        return s;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Present one item with random sender gaps and hold it until the engine takes it
    task automatic drive_item(input t_stim s);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {5'd0, s.sda, s.wb, s.cnt, s.reg_b, s.addr, s.kind};
        s_axis_tuser <= s.act;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Update the shadow state, queue the pin levels a tick produces, then send the item
    task automatic issue(input t_stim s, input t_chk chk);
        t_result r;
        case (s.act)
            ACT_BEGIN: begin
                if (bus_phase == PH_IDLE) begin
                    txn_kind = s.kind;
                    txn_addr = s.addr;
                    txn_reg = s.reg_b;
                    left_cnt = s.cnt;
                    if ((s.kind == KIND_REG_READ || s.kind == KIND_READ) && s.cnt == 8'd0)
                        left_cnt = 8'd1;
                    pend_ok = 1'b0;
                    ack_cnt = '0;
                    if (s.kind == KIND_READ) load_byte(s.addr, AA_READ, PH_START);
                    else if (s.kind == KIND_CMD_WRITE) load_byte(s.addr, AA_GAP, PH_START);
                    else load_byte(s.addr, AA_REG, PH_START);
                end
            end
            ACT_SUPPLY: begin
                pend_byte = s.wb;
                pend_ok = 1'b1;
            end
            default: begin
                r = tick_engine(s.sda);
                if (chk == CHK_IDLE_LINES) begin
                    r = '0;
                    {r.scl_level, r.sda_level, r.sda_driving} = 3'b111;
                end else if (r.done_res && chk == CHK_DONE_OK) begin
                    r.status = 1'b0;
                end else if (r.done_res && chk == CHK_DONE_FAIL) begin
                    r.status = 1'b1;
                end
                expected_pins.push_back(r);
            end
        endcase
        items_sent++;
        drive_item(s);
    endtask

    // Drain, then write both timing registers back to back
    task automatic program_timing(input logic [15:0] lim, input logic [7:0] gap);
        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge i_clk);
        // a begin or supply may still sit in the engine queue
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        for (int i = 0; i < 2; i++) begin
            i_cfg_index <= (i == 0) ? CFG_ACK_WAIT : CFG_CMD_GAP;
            i_cfg_data <= (i == 0) ? lim : {8'd0, gap};
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        ack_limit = lim;
        gap_len = gap;
    endtask

    // One I2C transfer with the slave answering per row.ack, ticking until the stop is out
    task automatic run_transfer(input t_row row, input bit noisy);
        t_stim s;
        int windows;
        windows = 0;
        repeat (row.pre_idle) issue(random_stim(ACT_TICK), CHK_IDLE_LINES);
        // supply while idle is dropped by the begin
        if (noisy) issue(random_stim(ACT_SUPPLY), CHK_MODEL);
        s = random_stim(ACT_BEGIN);
        s.kind = row.kind;
        s.addr = row.addr;
        s.reg_b = row.reg_b;
        s.cnt = row.cnt;
        issue(s, row.chk);
        // begin while busy is ignored
        if (noisy) issue(random_stim(ACT_BEGIN), CHK_MODEL);
        while (bus_phase != PH_IDLE) begin
            if (bus_phase == PH_NEED && !pend_ok)
                s = random_stim($urandom_range(1) ? ACT_SUPPLY : ACT_TICK);
            else if (txn_kind == KIND_REG_WRITE && $urandom_range(15) == 0)
                s = random_stim(ACT_SUPPLY);
            else
                s = random_stim(ACT_TICK);
            if (s.act == ACT_TICK && bus_phase == PH_AWAIT) begin
                case (row.ack)
                    ACK_NOW:   s.sda = 1'b0;
                    ACK_NEVER: s.sda = 1'b1;
                    ACK_LATE:  s.sda = ($urandom_range(2) != 0);
                    default:   s.sda = (windows != 0);
                endcase
            end
            if (s.act == ACT_TICK && bus_phase == PH_AEND) windows++;
            issue(s, row.chk);
        end
    endtask

    // Output side: random stalls and comparison with the oldest expectation
    always @(posedge i_clk) begin : pin_checker
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.scl_level = m_axis_tdata[0];
            got.sda_level = m_axis_tdata[1];
            got.sda_driving = m_axis_tdata[2];
            got.read_byte = m_axis_tdata[10:3];
            got.read_valid = m_axis_tdata[11];
            got.need_data = m_axis_tdata[12];
            got.status = m_axis_tdata[13];
            got.busy_res = m_axis_tdata[14];
            got.done_res = m_axis_tlast;
            if (expected_pins.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h last %b",
                         $time, m_axis_tdata, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_pins.pop_front();
                compare_field("scl_level", want.scl_level, got.scl_level);
                compare_field("sda_level", want.sda_level, got.sda_level);
                compare_field("sda_driving", want.sda_driving, got.sda_driving);
                compare_field("read_byte", want.read_byte, got.read_byte);
                compare_field("read_valid", want.read_valid, got.read_valid);
                compare_field("need_data", want.need_data, got.need_data);
                compare_field("done_res", want.done_res, got.done_res);
                compare_field("status", want.status, got.status);
                compare_field("busy_res", want.busy_res, got.busy_res);
            end
        end
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Stimulus
    initial begin : stimulus
        t_row row;
        int pick;
        int phase_start;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed transfers, no idling
        for (int i = 0; i < NROWS; i++) begin
            if (PLAN[i].ack_lim != ack_limit || PLAN[i].gap != gap_len)
                program_timing(PLAN[i].ack_lim, PLAN[i].gap);
            run_transfer(PLAN[i], 1'b1);
        end

        // random transfers under each idling pattern
        for (int p = 0; p < 4; p++) begin
            program_timing(($urandom_range(3) == 0) ? 16'd1 : 16'($urandom_range(30, 2)),
                           ($urandom_range(4) == 0) ? 8'd255 : 8'($urandom_range(6)));
            send_idle_pct = SEND_IDLE[p];
            recv_stall_pct = RECV_STALL[p];
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_PHASE) begin
                row = '0;
                row.kind = $urandom_range(3);
                row.addr = $urandom_range(255);
                row.reg_b = $urandom_range(255);
                if (row.kind == KIND_CMD_WRITE) row.cnt = $urandom_range(255);
                else if ($urandom_range(7) == 0) row.cnt = $urandom_range(40, 5);
                else row.cnt = $urandom_range(4);
                pick = $urandom_range(99);
                if (pick < 70) row.ack = ACK_NOW;
                else if (pick < 85) row.ack = ACK_LATE;
                else if (pick < 95) row.ack = ACK_NEVER;
                else row.ack = ACK_FIRST_ONLY;
                row.chk = CHK_MODEL;
                row.pre_idle = $urandom_range(3);
                run_transfer(row, $urandom_range(3) == 0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (expected_pins.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("i2c_master_transaction_engine test passed");
        end else begin
            $display("i2c_master_transaction_engine test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #8_000_000;
        $display("i2c_master_transaction_engine test failed");
        $finish;
    end

endmodule
